// ===== sv/ffpba_pkg.sv =====
`timescale 1ns / 1ps

package ffpba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 24;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int COUNT_W    = $clog2(MAX_BLOCKS + 1);

    localparam logic [31:0] HEAP_BASE_RESET  = 32'd65536;
    localparam logic [31:0] HEAP_LIMIT_RESET = 32'd1048576;

    localparam logic [7:0] REG_HEAP_BASE  = 8'd0;
    localparam logic [7:0] REG_HEAP_LIMIT = 8'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ZERO      = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FULL      = 3'd3,
        ST_UNKNOWN   = 3'd4,
        ST_DOUBLE    = 3'd5
    } status_t;

    // Search query that walks down the row of table cells, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic               is_free;
        logic [31:0]        key;
        logic [COUNT_W-1:0] remaining;
        logic               append;
        logic [31:0]        append_base;
        logic               hit;
        logic               hit_double;
        logic [31:0]        hit_addr;
    } query_t;

endpackage

// ===== sv/first_fit_page_block_allocator.sv =====
`timescale 1ns / 1ps

// Heap block allocator. An input transaction with action 0 allocates
// request_size bytes plus a header, rounded up to whole pages; action 1 frees
// the block whose user address is user_address. Each input transaction gives
// exactly one output transaction with result_address and status.
// The block table is a row of cells; a query steps through one cell per
// cycle, so a non-null free and an allocate that passes rounding take a full
// pass over all MAX_BLOCKS cells. An allocate rounds, checks space and scans;
// a non-null free only scans; a zero-size allocate or a null free ends at
// once, and one whose rounded size exceeds 32 bits ends after rounding. One
// transaction is in work at a time; a new one is accepted in the cycle after
// the previous result is written into the output register. If the receiver
// stalls, the finished result is held there and the next transaction waits
// for it to leave before its own result is written. Reset empties the table
// and the heap and restores heap_base and heap_limit; no clearing pass is
// needed. Registers are written through cfg_we/cfg_index/cfg_data only while
// no transaction is in work, a user rule that the block does not enforce.

module first_fit_page_block_allocator
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] request_size,
    input  logic [31:0] user_address,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result_address,
    output logic [2:0]  status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_CHECK,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;

    logic [31:0] heap_base_reg;
    logic [31:0] heap_limit_reg;
    logic [ffpba_pkg::COUNT_W-1:0] entry_count_reg;
    logic [31:0] heap_used_reg;

    logic        is_free_reg;
    logic [31:0] size_reg;
    logic [31:0] rounded_reg;
    logic [31:0] top_reg;
    ffpba_pkg::status_t append_status_reg;

    logic [31:0] res_addr_reg;
    ffpba_pkg::status_t res_status_reg;

    logic        out_valid_reg;
    logic [31:0] out_addr_reg;
    ffpba_pkg::status_t out_status_reg;

    ffpba_pkg::query_t launch_reg;
    ffpba_pkg::query_t chain [ffpba_pkg::MAX_BLOCKS+1];

    logic [33:0] round_sum;
    logic [33:0] rounded_full;
    logic [32:0] used_sum;
    logic [32:0] top_sum;
    logic [33:0] top_end;
    logic        table_full;
    ffpba_pkg::status_t check_status;
    logic [31:0] append_addr;
    ffpba_pkg::query_t scan_end;

    assign chain[0] = launch_reg;

    genvar g;
    generate
        for (g = 0; g < ffpba_pkg::MAX_BLOCKS; g++)
        begin : g_cell
            ffpba_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .q_in  (chain[g]),
                .q_out (chain[g+1])
            );
        end
    endgenerate

    assign scan_end = chain[ffpba_pkg::MAX_BLOCKS];

    always_comb
    begin
        round_sum    = {2'b00, size_reg} + 34'(ffpba_pkg::HEADER_BYTES)
                       + 34'(ffpba_pkg::PAGE_BYTES - 1);
        rounded_full = (round_sum >> ffpba_pkg::PAGE_SHIFT) << ffpba_pkg::PAGE_SHIFT;

        used_sum   = {1'b0, heap_used_reg} + {1'b0, rounded_reg};
        top_sum    = {1'b0, heap_base_reg} + {1'b0, heap_used_reg};
        top_end    = {1'b0, top_sum} + {2'b00, rounded_reg};
        table_full = (entry_count_reg == ffpba_pkg::COUNT_W'(ffpba_pkg::MAX_BLOCKS));

        if (table_full)
        begin
            check_status = ffpba_pkg::ST_FULL;
        end
        else if (used_sum > {1'b0, heap_limit_reg})
        begin
            check_status = ffpba_pkg::ST_EXHAUSTED;
        end
        else if (top_end > 34'h1_0000_0000)
        begin
            check_status = ffpba_pkg::ST_EXHAUSTED;
        end
        else
        begin
            check_status = ffpba_pkg::ST_OK;
        end

        append_addr = top_reg + 32'(ffpba_pkg::HEADER_BYTES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            heap_base_reg     <= ffpba_pkg::HEAP_BASE_RESET;
            heap_limit_reg    <= ffpba_pkg::HEAP_LIMIT_RESET;
            entry_count_reg   <= '0;
            heap_used_reg     <= '0;
            is_free_reg       <= 1'b0;
            size_reg          <= '0;
            rounded_reg       <= '0;
            top_reg           <= '0;
            append_status_reg <= ffpba_pkg::ST_OK;
            res_addr_reg      <= '0;
            res_status_reg    <= ffpba_pkg::ST_OK;
            out_valid_reg     <= 1'b0;
            out_addr_reg      <= '0;
            out_status_reg    <= ffpba_pkg::ST_OK;
            launch_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    ffpba_pkg::REG_HEAP_BASE:
                    begin
                        if (cfg_data != '0)
                        begin
                            heap_base_reg <= cfg_data;
                        end
                    end
                    ffpba_pkg::REG_HEAP_LIMIT:
                    begin
                        heap_limit_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        is_free_reg <= action;
                        size_reg    <= request_size;
                        res_addr_reg <= '0;
                        if (!action)
                        begin
                            if (request_size == '0)
                            begin
                                res_status_reg <= ffpba_pkg::ST_ZERO;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_ROUND;
                            end
                        end
                        else if (user_address == '0)
                        begin
                            res_status_reg <= ffpba_pkg::ST_OK;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            launch_reg.valid       <= 1'b1;
                            launch_reg.is_free     <= 1'b1;
                            launch_reg.key         <= user_address;
                            launch_reg.remaining   <= entry_count_reg;
                            launch_reg.append      <= 1'b0;
                            launch_reg.append_base <= '0;
                            launch_reg.hit         <= 1'b0;
                            launch_reg.hit_double  <= 1'b0;
                            launch_reg.hit_addr    <= '0;
                            state_reg              <= S_SCAN;
                        end
                    end
                end

                S_ROUND:
                begin
                    if (rounded_full[33:32] != 2'b00)
                    begin
                        res_status_reg <= ffpba_pkg::ST_EXHAUSTED;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        rounded_reg <= rounded_full[31:0];
                        state_reg   <= S_CHECK;
                    end
                end

                S_CHECK:
                begin
                    // Table and heap space are settled here; a reused block
                    // found by the scan still takes precedence.
                    append_status_reg      <= check_status;
                    top_reg                <= top_sum[31:0];
                    launch_reg.valid       <= 1'b1;
                    launch_reg.is_free     <= 1'b0;
                    launch_reg.key         <= rounded_reg;
                    launch_reg.remaining   <= entry_count_reg;
                    launch_reg.append      <= (check_status == ffpba_pkg::ST_OK);
                    launch_reg.append_base <= top_sum[31:0];
                    launch_reg.hit         <= 1'b0;
                    launch_reg.hit_double  <= 1'b0;
                    launch_reg.hit_addr    <= '0;
                    state_reg              <= S_SCAN;
                end

                S_SCAN:
                begin
                    // The query enters the first cell for one cycle only.
                    launch_reg.valid <= 1'b0;
                    if (scan_end.valid)
                    begin
                        state_reg <= S_DONE;
                        if (!is_free_reg)
                        begin
                            if (scan_end.hit)
                            begin
                                res_addr_reg   <= scan_end.hit_addr;
                                res_status_reg <= ffpba_pkg::ST_OK;
                            end
                            else if (append_status_reg == ffpba_pkg::ST_OK)
                            begin
                                res_addr_reg    <= append_addr;
                                res_status_reg  <= ffpba_pkg::ST_OK;
                                entry_count_reg <= entry_count_reg + 1'b1;
                                heap_used_reg   <= heap_used_reg + rounded_reg;
                            end
                            else
                            begin
                                res_addr_reg   <= '0;
                                res_status_reg <= append_status_reg;
                            end
                        end
                        else if (scan_end.hit)
                        begin
                            res_status_reg <= scan_end.hit_double ? ffpba_pkg::ST_DOUBLE
                                                                  : ffpba_pkg::ST_OK;
                        end
                        else
                        begin
                            res_status_reg <= ffpba_pkg::ST_UNKNOWN;
                        end
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_addr_reg   <= res_addr_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;

endmodule

// ===== sv/ffpba_cell.sv =====
`timescale 1ns / 1ps

module ffpba_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  ffpba_pkg::query_t q_in,
    output ffpba_pkg::query_t q_out
);

    logic [31:0] base_reg;
    logic [31:0] bytes_reg;
    logic        free_reg;
    logic [31:0] base_next;
    logic [31:0] bytes_next;
    logic        free_next;

    ffpba_pkg::query_t q_reg;
    ffpba_pkg::query_t q_next;

    logic        live;
    logic [32:0] user_addr;
    logic        alloc_match;
    logic        free_match;
    logic        append_here;

    always_comb
    begin
        live        = q_in.valid && (q_in.remaining != '0) && !q_in.hit;
        user_addr   = {1'b0, base_reg} + 33'(ffpba_pkg::HEADER_BYTES);
        alloc_match = live && !q_in.is_free && free_reg && (bytes_reg == q_in.key);
        free_match  = live && q_in.is_free && (user_addr == {1'b0, q_in.key});
        // The first cell past the used part of the table takes a new block.
        append_here = q_in.valid && (q_in.remaining == '0) && q_in.append && !q_in.hit;

        q_next = q_in;
        if (q_in.remaining != '0)
        begin
            q_next.remaining = q_in.remaining - 1'b1;
        end
        if (alloc_match || free_match)
        begin
            q_next.hit        = 1'b1;
            q_next.hit_double = free_reg && q_in.is_free;
            q_next.hit_addr   = user_addr[31:0];
        end
        if (append_here)
        begin
            q_next.append = 1'b0;
        end

        base_next  = base_reg;
        bytes_next = bytes_reg;
        free_next  = free_reg;
        if (alloc_match)
        begin
            free_next = 1'b0;
        end
        else if (free_match)
        begin
            free_next = 1'b1;
        end
        else if (append_here)
        begin
            base_next  = q_in.append_base;
            bytes_next = q_in.key;
            free_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        bytes_reg <= bytes_next;
        free_reg  <= free_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else
        begin
            q_reg <= q_next;
        end
    end

    assign q_out = q_reg;

endmodule
